FILE: hdl/isort_pkg.sv
`timescale 1ns / 1ps

package isort_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int IDX_W     = $clog2(MAX_ITEMS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // take the input request: insert, or drop when full
        logic advance;  // step the read index to the next entry
        logic finish;   // clear count, drop flag and read index
    } isort_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;     // read index is at the last stored entry
        logic empty;
    } isort_stat_t;

endpackage

FILE: hdl/isort_datapath.sv
`timescale 1ns / 1ps

module isort_datapath
    import isort_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  isort_cmd_t               cmd,
    input  logic signed [DATA_W-1:0] sample_value,
    output isort_stat_t              stat,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     overflowed
);

    logic signed [DATA_W-1:0] store_reg  [MAX_ITEMS];
    logic signed [DATA_W-1:0] store_next [MAX_ITEMS];
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic                     drop_reg;
    logic                     drop_next;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic [IDX_W-1:0]         rd_idx_next;
    logic [MAX_ITEMS-1:0]     gt;
    logic [MAX_ITEMS-1:0]     gt_below;
    logic                     full;
    logic                     do_insert;

    assign full      = (fill_reg == CNT_W'(MAX_ITEMS));
    assign do_insert = cmd.accept && !full;

    // Every stored entry compares against the new value at once
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            gt[i] = (CNT_W'(i) < fill_reg) && (store_reg[i] > sample_value);
        end
    end

    assign gt_below = {gt[MAX_ITEMS-2:0], 1'b0};

    // Shift greater entries up one place; drop the value into the gap
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            store_next[i] = store_reg[i];
            if (do_insert)
            begin
                if (gt_below[i])
                begin
                    store_next[i] = store_reg[(i == 0) ? 0 : i - 1];
                end
                else if (gt[i] || (CNT_W'(i) == fill_reg))
                begin
                    store_next[i] = sample_value;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

    always_comb
    begin
        fill_next   = fill_reg;
        drop_next   = drop_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.finish)
        begin
            fill_next   = '0;
            drop_next   = 1'b0;
            rd_idx_next = '0;
        end
        else
        begin
            if (do_insert)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
            if (cmd.accept && full)
            begin
                drop_next = 1'b1;
            end
            if (cmd.advance)
            begin
                rd_idx_next = rd_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            drop_reg   <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            drop_reg   <= drop_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign stat.empty   = (fill_reg == '0);
    assign stat.last    = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == fill_reg);
    assign sorted_value = store_reg[rd_idx_reg];
    assign overflowed   = drop_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count above store depth");
    a_advance_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> ((CNT_W'(rd_idx_reg) + CNT_W'(1)) < fill_reg))
        else $error("read index stepped past the stored list");
    a_drop_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (drop_next && !drop_reg) |-> full)
        else $error("drop flag set with room in the store");
`endif

endmodule

FILE: hdl/isort_controller.sv
`timescale 1ns / 1ps

module isort_controller
    import isort_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        final_item,
    input  logic        out_ready,
    input  isort_stat_t stat,
    output logic        in_ready,
    output logic        out_valid,
    output logic        run_end,
    output isort_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_COLLECT = 2'b01,
        ST_EMIT    = 2'b10
    } isort_state_t;

    isort_state_t state_reg;
    isort_state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.accept  = 1'b0;
        cmd.advance = 1'b0;
        cmd.finish  = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && final_item)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (stat.last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_COLLECT;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    assign run_end = stat.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !stat.empty)
        else $error("emitting from an empty store");
    a_final_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && final_item) |=> out_valid)
        else $error("final request did not start output");
    a_end_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && run_end) |=> (in_ready && stat.empty))
        else $error("list end did not return to collection");
`endif

endmodule

FILE: hdl/insertion_sorter_unit.sv
`timescale 1ns / 1ps

// Stable streaming insertion sorter for signed 32-bit values. Each input
// request carries one value and is inserted into a sorted store of
// MAX_ITEMS entries: every entry compares against the new value in
// parallel, greater entries shift up one place and the value lands
// after any equal ones. While collecting, the block takes one request per
// cycle. A request with final_item set ends the list: input stalls and the
// stored list comes out in ascending order, one result per cycle while
// out_ready is high, with run_end on the last result. The output comes
// from the single read port on the store. Values that arrive while the
// store is full (including a final one) are dropped, and overflowed is
// high on every result of that list. After the last result the store is
// empty again.

module insertion_sorter_unit
    import isort_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DATA_W-1:0] sample_value,
    input  logic                     final_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     run_end,
    output logic                     overflowed
);

    isort_cmd_t  cmd;
    isort_stat_t stat;

    // Sequence collection and output; hold input while the list drains
    isort_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .final_item (final_item),
        .out_ready  (out_ready),
        .stat       (stat),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .run_end    (run_end),
        .cmd        (cmd)
    );

    // Sorted store with parallel compare-and-shift insert and read index
    isort_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sample_value (sample_value),
        .stat         (stat),
        .sorted_value (sorted_value),
        .overflowed   (overflowed)
    );

endmodule
